// ----- rtl/ocbc_pkg.sv -----
// Shared types and constants of the outer-code encoder.
// Holds the 32-bit CRC and BCH generator constants and the register codes; no dependencies.
package ocbc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SHORT_FRM = 2'd0;
  localparam logic [1:0] CFG_CODE_RATE = 2'd1;
  localparam logic [1:0] CFG_FEC_MODE  = 2'd2;

  // Check modes; the spare code acts as no check.
  localparam logic [1:0] FEC_NONE = 2'd0;
  localparam logic [1:0] FEC_CRC  = 2'd1;
  localparam logic [1:0] FEC_BCH  = 2'd2;

  localparam logic [3:0] RATE_MIN = 4'd2;
  localparam logic [3:0] RATE_MAX = 4'd13;

  localparam logic [9:0] STEP_NORMAL = 10'd540;
  localparam logic [9:0] STEP_SHORT  = 10'd135;

  localparam logic [4:0] CHK_CRC        = 5'd4;
  localparam logic [4:0] CHK_BCH_NORMAL = 5'd24;
  localparam logic [4:0] CHK_BCH_SHORT  = 5'd21;

  localparam logic [31:0] CRC_POLY = 32'h0021_0801;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int PAR_W   = 192;
  localparam int SHORT_W = 168;

  // Minimal polynomials, 17 bits per entry.
  localparam logic [203:0] NORMAL_MINPOLY = {
    17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
    17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3
  };
  localparam logic [203:0] SHORT_MINPOLY = {
    17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
    17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF
  };

  // GF(2) product of the twelve minimal polynomials, leading term dropped.
  function automatic logic [PAR_W-1:0] gen_poly(input logic [203:0] mins,
                                                 input logic short_sel);
    logic [207:0] acc;
    logic [207:0] sum;
    int i;
    int k;
    acc = 208'd1;
    for (i = 0; i < 12; i++) begin
      sum = '0;
      for (k = 0; k < 17; k++) begin
        if (mins[i*17+k]) sum = sum ^ (acc << k);
      end
      acc = sum;
    end
    if (short_sel) return {24'b0, acc[SHORT_W-1:0]};
    return acc[PAR_W-1:0];
  endfunction

  localparam logic [PAR_W-1:0] GEN_NORMAL = gen_poly(NORMAL_MINPOLY, 1'b0);
  localparam logic [PAR_W-1:0] GEN_SHORT  = gen_poly(SHORT_MINPOLY, 1'b1);

  // Update control for both check registers.
  typedef struct packed {
    logic shift;    // absorb one byte
    logic restart;  // reload for the next frame
  } lfsr_ctl_t;

  // One result waiting in the output queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ----- rtl/ocbc_crc32.sv -----
// 32-bit CRC register with a byte-wide unrolled update, MSB first.
// Depends on ocbc_pkg for the polynomial, initial value and control struct.
module ocbc_crc32 import ocbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lfsr_ctl_t   ctl,
  input  logic [7:0]  data,
  output logic [31:0] crc_upd
);

  logic [31:0] crc_reg;

  always_comb begin
    logic [31:0] c;
    logic        fb;
    c = crc_reg;
    for (int e = 0; e < 8; e++) begin
      fb = c[31] ^ data[7-e];
      c  = c << 1;
      if (fb) c = c ^ CRC_POLY;
    end
    crc_upd = c;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      crc_reg <= CRC_INIT;
    end else if (ctl.shift) begin
      crc_reg <= crc_upd;
    end
  end

endmodule

// ----- rtl/ocbc_bch.sv -----
// BCH parity register with a byte-wide unrolled division by the generator.
// Depends on ocbc_pkg for the generators and control struct.
module ocbc_bch import ocbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lfsr_ctl_t        ctl,
  input  logic             short_frm,
  input  logic [7:0]       data,
  output logic [PAR_W-1:0] par_upd
);

  logic [PAR_W-1:0] parity_reg;

  // Feedback tap and upper clear follow the current degree.
  always_comb begin
    logic [PAR_W-1:0] p;
    logic             fb;
    p = parity_reg;
    for (int e = 0; e < 8; e++) begin
      fb = (short_frm ? p[SHORT_W-1] : p[PAR_W-1]) ^ data[7-e];
      p  = p << 1;
      if (short_frm) p[PAR_W-1:SHORT_W] = '0;
      if (fb) p = p ^ (short_frm ? GEN_SHORT : GEN_NORMAL);
    end
    par_upd = p;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      parity_reg <= '0;
    end else if (ctl.shift) begin
      parity_reg <= par_upd;
    end
  end

endmodule

// ----- rtl/ocbc_outq.sv -----
// Two-entry result queue that decouples the encoder from the output handshake.
// Depends on ocbc_pkg for the result struct.
module ocbc_outq import ocbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t wdata,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output res_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  res_t       q0;
  res_t       q1;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q0;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (count == 2'd2) ? q1 : wdata;
    end else if (push) begin
      if (count == 2'd0) q0 <= wdata;
      else q1 <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full result queue");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1)
    else $error("pop did not drain an entry");
`endif

endmodule

// ----- rtl/outer_code_bch_crc_encoder_core.sv -----
// Top level of the outer-code encoder: config registers, frame counting, check append.
// Depends on ocbc_pkg, ocbc_crc32, ocbc_bch and ocbc_outq.
//
//   channel   signals                                 direction  moves
//   input     in_valid, in_ready, data_byte           in         one payload byte per request
//   output    out_valid, out_ready, out_byte,         out        one coded byte per request
//             frame_end
//   config    cfg_write, cfg_index, cfg_data          in         one register write, no wait
//
// Each accepted payload byte is absorbed by both check registers through an eight-bit
// unrolled LFSR update, and the echoed byte enters the output queue at the same edge.
// After the last payload byte of a frame, 0, 4, 21 or 24 check bytes drain from a shift
// register into the queue, one per cycle while it has room; input requests are held off then.
// Reset is synchronous and needs no clearing pass; the frame starts at byte zero.
// The two-entry output queue keeps input flowing while a result waits on out_ready.
module outer_code_bch_crc_encoder_core import ocbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // payload input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  // coded output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_end,
  // configuration writes
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  // Number of check bytes appended for a mode and frame size.
  function automatic logic [4:0] check_calc(input logic size, input logic [1:0] mode);
    logic [4:0] n;
    unique case (mode)
      FEC_CRC: n = CHK_CRC;
      FEC_BCH: n = size ? CHK_BCH_SHORT : CHK_BCH_NORMAL;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // Payload length in bytes: clamped rate times the step, less the check bytes.
  function automatic logic [12:0] payload_calc(input logic size, input logic [3:0] rate,
                                               input logic [1:0] mode);
    logic [3:0]  r;
    logic [13:0] prod;
    r = rate;
    if (rate < RATE_MIN) r = RATE_MIN;
    if (rate > RATE_MAX) r = RATE_MAX;
    prod = size ? (14'(r) * 14'(STEP_SHORT)) : (14'(r) * 14'(STEP_NORMAL));
    return prod[12:0] - {8'b0, check_calc(size, mode)};
  endfunction

  // Config registers and the frame geometry derived from them.
  logic        short_frm;
  logic [3:0]  code_rate;
  logic [1:0]  fec_mode;
  logic        short_frm_next;
  logic [3:0]  code_rate_next;
  logic [1:0]  fec_mode_next;
  logic [12:0] payload_len;
  logic [4:0]  check_num;

  // Frame progress and check append.
  logic [12:0]      byte_count;
  logic [12:0]      cnt_inc;
  logic [4:0]       chk_left;
  logic [PAR_W-1:0] chk_sr;
  logic             accept;
  logic             pay_end;

  lfsr_ctl_t        lfsr_ctl;
  logic [31:0]      crc_upd;
  logic [PAR_W-1:0] par_upd;

  logic q_push;
  res_t q_wdata;
  logic q_full;
  res_t q_head;

  // Writes take effect at the edge; derived lengths follow from the new values.
  always_comb begin
    short_frm_next = short_frm;
    code_rate_next = code_rate;
    fec_mode_next  = fec_mode;
    if (cfg_write && cfg_index == CFG_SHORT_FRM) short_frm_next = cfg_data[0];
    if (cfg_write && cfg_index == CFG_CODE_RATE) code_rate_next = cfg_data;
    if (cfg_write && cfg_index == CFG_FEC_MODE)  fec_mode_next  = cfg_data[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_frm   <= 1'b0;
      code_rate   <= RATE_MIN;
      fec_mode    <= FEC_BCH;
      payload_len <= payload_calc(1'b0, RATE_MIN, FEC_BCH);
      check_num   <= check_calc(1'b0, FEC_BCH);
    end else begin
      short_frm   <= short_frm_next;
      code_rate   <= code_rate_next;
      fec_mode    <= fec_mode_next;
      payload_len <= payload_calc(short_frm_next, code_rate_next, fec_mode_next);
      check_num   <= check_calc(short_frm_next, fec_mode_next);
    end
  end

  // Hold off input while check bytes drain or the queue is full.
  assign in_ready = (chk_left == 5'd0) && !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = byte_count + 13'd1;
  assign pay_end  = accept && (cnt_inc >= payload_len);

  assign lfsr_ctl.shift   = accept;
  assign lfsr_ctl.restart = pay_end;

  ocbc_crc32 u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lfsr_ctl),
    .data    (data_byte),
    .crc_upd (crc_upd)
  );

  ocbc_bch u_bch (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lfsr_ctl),
    .short_frm (short_frm),
    .data      (data_byte),
    .par_upd   (par_upd)
  );

  // Echo the payload byte; otherwise push the next check byte when there is room.
  always_comb begin
    q_push  = 1'b0;
    q_wdata = '0;
    if (accept) begin
      q_push       = 1'b1;
      q_wdata.data = data_byte;
      q_wdata.last = pay_end && (check_num == 5'd0);
    end else if (chk_left != 5'd0 && !q_full) begin
      q_push       = 1'b1;
      q_wdata.data = chk_sr[PAR_W-1 -: 8];
      q_wdata.last = (chk_left == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 13'd0;
      chk_left   <= 5'd0;
    end else if (accept) begin
      byte_count <= pay_end ? 13'd0 : cnt_inc;
      if (pay_end) chk_left <= check_num;
    end else if (chk_left != 5'd0 && !q_full) begin
      chk_left <= chk_left - 5'd1;
    end
  end

  // Snapshot the finished check word left-aligned, then advance a byte per push.
  always_ff @(posedge clk) begin
    if (pay_end) begin
      if (fec_mode == FEC_CRC) chk_sr <= {crc_upd, {(PAR_W-32){1'b0}}};
      else if (short_frm)      chk_sr <= {par_upd[SHORT_W-1:0], {(PAR_W-SHORT_W){1'b0}}};
      else                     chk_sr <= par_upd;
    end else if (chk_left != 5'd0 && !q_full) begin
      chk_sr <= chk_sr << 8;
    end
  end

  ocbc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wdata      (q_wdata),
    .pop        (out_valid && out_ready),
    .full       (q_full),
    .head_valid (out_valid),
    .head       (q_head)
  );

  assign out_byte  = q_head.data;
  assign frame_end = q_head.last;

`ifndef NO_ASSERTIONS
  a_check_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pay_end && check_num != 5'd0 |=> chk_left != 5'd0 && !in_ready)
    else $error("input taken while check bytes pending");
  a_check_countdown: assert property (@(posedge clk) disable iff (rst)
    chk_left != 5'd0 && !q_full |=> chk_left == $past(chk_left) - 5'd1)
    else $error("check byte counter did not advance");
  a_byte_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !pay_end |=> byte_count == $past(byte_count) + 13'd1)
    else $error("byte count did not advance on payload byte");
`endif

endmodule

// ----- tb/sv/tb_outer_code_bch_crc_encoder_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the outer-code encoder (payload echo plus 32-bit CRC or BCH check).
// Depends on ocbc_pkg and outer_code_bch_crc_encoder_core; needs no files or arguments.
module tb_outer_code_bch_crc_encoder_core;
  import ocbc_pkg::*;

  // Register index with no register behind it, and the spare check mode.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] FEC_SPARE = 2'd3;

  localparam int WATCH_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, enough to back up the input
  localparam int TAIL_CYCLES = 40;    // quiet cycles after the last expected byte
  localparam int PLAN_ROWS   = 23;
  localparam int PHASE_BYTES = 80;    // random payload bytes per idling phase

  // Check generators, kept apart from the package constants.
  localparam logic [31:0] CRC32_TAPS = 32'h0021_0801;
  localparam logic [31:0] CRC32_SEED = 32'hFFFF_FFFF;
  localparam int NRM_DEG   = 192;
  localparam int SHT_DEG   = 168;
  localparam int STEP_NRM  = 540;
  localparam int STEP_SHT  = 135;
  localparam int CRC_BYTES = 4;
  localparam logic [203:0] NRM_MINPOLY = {
    17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
    17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3
  };
  localparam logic [203:0] SHT_MINPOLY = {
    17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
    17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF
  };

  // One coded byte as the output side should deliver it.
  typedef struct packed {
    logic [7:0] data;
    logic       fend;
  } coded_t;

  // Directed stimulus: a register write or one payload byte. Pinned rows carry a
  // typed-in echo; every other row is checked against the encoder model below.
  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;
  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] idx;
    logic [3:0] val;
    logic [7:0] b;
    logic       pinned;
    logic [7:0] exp_b;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  // Typed expectation riding along with the byte on the input port.
  logic       pin_on;
  logic [7:0] pin_byte;

  // Encoder model: register mirror and check state.
  logic         cur_size = 1'b0;
  logic [3:0]   cur_rate = RATE_MIN;
  logic [1:0]   cur_mode = FEC_BCH;
  logic [191:0] par_reg  = '0;
  logic [31:0]  crc_acc  = CRC32_SEED;
  logic [12:0]  byte_cnt = '0;
  logic [191:0] gen_nrm;
  logic [191:0] gen_sht;

  coded_t    coded_q[$];      // coded bytes still owed by the block, oldest first
  coded_t    head_exp;
  int        frames_closed = 0;
  int        err_cnt       = 0;
  int        stall_cnt     = 0;
  int        tx_idle_pct   = 0;
  int        rx_idle_pct   = 0;
  int        hold_req      = 0;
  int        hold_served   = 0;
  plan_row_t plan [PLAN_ROWS];

  outer_code_bch_crc_encoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // GF(2) product of twelve minimal polynomials, leading term dropped. For the short
  // code only the low 168 bits belong to the generator.
  function automatic logic [191:0] poly_product(input logic [203:0] mins, input int deg);
    logic [207:0] acc;
    logic [207:0] sum;
    int i;
    int k;
    acc = 208'd1;
    for (i = 0; i < 12; i++) begin
      sum = '0;
      for (k = 0; k < 17; k++) begin
        if (mins[i*17+k]) sum = sum ^ (acc << k);
      end
      acc = sum;
    end
    poly_product = acc[191:0];
    if (deg == SHT_DEG) poly_product[NRM_DEG-1:SHT_DEG] = '0;
  endfunction

  // Absorb one accepted payload byte: advance both check registers bit by bit, MSB
  // first, queue the echo, and queue the check bytes once the payload is complete.
  task automatic encode_byte(input logic [7:0] b, input logic pin, input logic [7:0] pin_b);
    int rate;
    int deg;
    int n_chk;
    int pay;
    int e;
    int k;
    logic fb;
    logic [7:0] chk_b;
    // Clamp the rate; the spare mode appends nothing.
    if (cur_rate < RATE_MIN)      rate = int'(RATE_MIN);
    else if (cur_rate > RATE_MAX) rate = int'(RATE_MAX);
    else                          rate = int'(cur_rate);
    deg = cur_size ? SHT_DEG : NRM_DEG;
    case (cur_mode)
      FEC_CRC: n_chk = CRC_BYTES;
      FEC_BCH: n_chk = deg / 8;
      default: n_chk = 0;
    endcase
    pay = rate * (cur_size ? STEP_SHT : STEP_NRM) - n_chk;

    // Both registers run on every byte, whatever the mode. The BCH register shifts
    // at the current degree and keeps its bits across a size change.
    for (e = 7; e >= 0; e--) begin
      fb = crc_acc[31] ^ b[e];
      crc_acc = crc_acc << 1;
      if (fb) crc_acc = crc_acc ^ CRC32_TAPS;
      fb = par_reg[deg-1] ^ b[e];
      par_reg = par_reg << 1;
      if (cur_size) par_reg[NRM_DEG-1:SHT_DEG] = '0;
      if (fb) par_reg = par_reg ^ (cur_size ? gen_sht : gen_nrm);
    end
    coded_q.push_back(pin ? {pin_b, 1'b0} : {b, 1'b0});
    byte_cnt = byte_cnt + 13'd1;

    // A late write may leave the count already past the payload: close on this byte.
    if (int'(byte_cnt) >= pay) begin
      for (k = 0; k < n_chk; k++) begin
        chk_b = (cur_mode == FEC_CRC) ? crc_acc[31-8*k -: 8] : par_reg[deg-1-8*k -: 8];
        coded_q.push_back({chk_b, 1'b0});
      end
      coded_q[coded_q.size()-1].fend = 1'b1;
      par_reg = '0;
      crc_acc = CRC32_SEED;
      byte_cnt = '0;
      frames_closed++;
    end
  endtask

  // Predict on every accepted request, then check every delivered byte against the
  // oldest expectation. Prediction goes first so queue order holds at any latency.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) encode_byte(data_byte, pin_on, pin_byte);
      if (out_valid && out_ready) begin
        if (coded_q.size() == 0) begin
          $error("out_byte: no request pending, got %h (frame_end %0b)", out_byte, frame_end);
          err_cnt++;
        end else begin
          head_exp = coded_q.pop_front();
          if (out_byte !== head_exp.data) begin
            $error("out_byte: expected %h, got %h", head_exp.data, out_byte);
            err_cnt++;
          end
          if (frame_end !== head_exp.fend) begin
            $error("frame_end: expected %0b, got %0b", head_exp.fend, frame_end);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: any handshake or register write resets the count of dead cycles.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= WATCH_LIMIT) begin
        $display("tb_outer_code_bch_crc_encoder_core: errors");
        $finish;
      end
    end
  end

  // Receiver: drop out_ready at random, or for a long stretch when a hold-off is
  // requested, so the block backs up into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // Offer one payload byte and hold it until the request is taken. Called and returns
  // at a falling edge; valid stays high so the next call can follow back to back.
  task automatic send_byte(input logic [7:0] b, input logic pin, input logic [7:0] pin_b);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    pin_on <= pin;
    pin_byte <= pin_b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected byte has come out.
  task automatic drain_out;
    in_valid <= 1'b0;
    do @(negedge clk); while (coded_q.size() != 0);
  endtask

  // One register write; the model mirror takes it at the same edge as the block.
  task automatic reg_write(input logic [1:0] idx, input logic [3:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SHORT_FRM: cur_size = val[0];
      CFG_CODE_RATE: cur_rate = val;
      CFG_FEC_MODE:  cur_mode = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Feed random payload until the model closes the current frame.
  task automatic close_frame;
    int f0;
    f0 = frames_closed;
    while (frames_closed == f0) send_byte(8'($urandom), 1'b0, 8'h00);
  endtask

  initial begin
    int ph;
    logic [3:0] junk;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = CFG_SHORT_FRM;
    cfg_data = 4'h0;
    pin_on = 1'b0;
    pin_byte = 8'h00;
    gen_nrm = poly_product(NRM_MINPOLY, NRM_DEG);
    gen_sht = poly_product(SHT_MINPOLY, SHT_DEG);

    // Directed rows. Right after reset the block echoes as-is (normal size, rate 2,
    // BCH), so the first bytes carry typed-in echoes.
    plan[0]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h00, 1'b1, 8'h00};
    plan[1]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'hFF, 1'b1, 8'hFF};
    plan[2]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h80, 1'b1, 8'h80};
    plan[3]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h01, 1'b1, 8'h01};
    // rate below the range acts as the lowest rate
    plan[4]  = '{ROW_WRITE, CFG_CODE_RATE, 4'h0, 8'h00, 1'b0, 8'h00};
    plan[5]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h5A, 1'b0, 8'h00};
    // rate above the range acts as the highest rate
    plan[6]  = '{ROW_WRITE, CFG_CODE_RATE, 4'hF, 8'h00, 1'b0, 8'h00};
    plan[7]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'hA5, 1'b1, 8'hA5};
    // spare mode behaves as no check
    plan[8]  = '{ROW_WRITE, CFG_FEC_MODE,  {2'b00, FEC_SPARE}, 8'h00, 1'b0, 8'h00};
    plan[9]  = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h3C, 1'b0, 8'h00};
    plan[10] = '{ROW_WRITE, CFG_FEC_MODE,  {2'b00, FEC_CRC}, 8'h00, 1'b0, 8'h00};
    plan[11] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'hC3, 1'b0, 8'h00};
    // size change in the middle of a frame
    plan[12] = '{ROW_WRITE, CFG_SHORT_FRM, 4'h1, 8'h00, 1'b0, 8'h00};
    plan[13] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h7E, 1'b0, 8'h00};
    plan[14] = '{ROW_WRITE, CFG_FEC_MODE,  {2'b00, FEC_NONE}, 8'h00, 1'b0, 8'h00};
    plan[15] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h81, 1'b0, 8'h00};
    // write to the empty index must change nothing
    plan[16] = '{ROW_WRITE, CFG_SPARE,     4'hF, 8'h00, 1'b0, 8'h00};
    plan[17] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'h55, 1'b0, 8'h00};
    // upper data bits beyond each register are dropped
    plan[18] = '{ROW_WRITE, CFG_SHORT_FRM, 4'hE, 8'h00, 1'b0, 8'h00};
    plan[19] = '{ROW_WRITE, CFG_FEC_MODE,  {2'b01, FEC_BCH}, 8'h00, 1'b0, 8'h00};
    plan[20] = '{ROW_WRITE, CFG_CODE_RATE, RATE_MIN, 8'h00, 1'b0, 8'h00};
    plan[21] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'hAA, 1'b0, 8'h00};
    plan[22] = '{ROW_BYTE,  CFG_SHORT_FRM, 4'h0, 8'hFF, 1'b0, 8'h00};

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 27;
    rx_idle_pct = 87;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_out();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].b, plan[i].pinned, plan[i].exp_b);
      end
    end

    // Random payload in three idling phases: slow receiver, slow sender, then none.
    // The frame stays at normal size so it stays open; mode and rate change between
    // phases. The last phase opens with the long hold-off.
    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 87 : 0;
      rx_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 27 : 0;
      if (ph == 2) hold_req++;
      repeat (PHASE_BYTES) send_byte(8'($urandom), 1'b0, 8'h00);
      if (ph < 2) begin
        drain_out();
        junk = 4'($urandom);
        reg_write(CFG_FEC_MODE, junk);
        junk = 4'($urandom);
        reg_write(CFG_CODE_RATE, junk);
      end
    end

    // Shrink the frame to short size, lowest rate, BCH. The count already sits past the
    // new payload length, so the next byte closes the frame after the BCH register has
    // changed degree with bits in it.
    drain_out();
    junk = 4'($urandom);
    reg_write(CFG_SHORT_FRM, {junk[3:1], 1'b1});
    junk = 4'($urandom_range(2, 0));
    reg_write(CFG_CODE_RATE, junk);
    junk = 4'($urandom);
    reg_write(CFG_FEC_MODE, {junk[3:2], FEC_BCH});
    close_frame();

    // Let the last bytes out, then watch for strays.
    drain_out();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0 && coded_q.size() == 0) begin
      $display("tb_outer_code_bch_crc_encoder_core: clean");
    end else begin
      $display("tb_outer_code_bch_crc_encoder_core: errors");
    end
    $finish;
  end

endmodule
